@@ hdl/channel_change_reporter_unit_macros.svh @@
// assertion macros shared by the channel change reporter modules
`ifndef CHANNEL_CHANGE_REPORTER_UNIT_MACROS_SVH
`define CHANNEL_CHANGE_REPORTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ccr assertion failed");
`define CCR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ccr assertion failed");
`else
`define CCR_ASSERT(lbl, prop)
`define CCR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ hdl/ccr_pkg.sv @@
// types and constants of the channel change reporter
package ccr_pkg;

  typedef enum logic {
    OP_STATUS  = 1'b0,
    OP_COMMAND = 1'b1
  } op_e;

  typedef enum logic {
    KIND_REPORT  = 1'b0,
    KIND_COMMAND = 1'b1
  } kind_e;

  localparam logic [2:0]  ADDR_TIMEOUT_IDX = 3'd0;
  localparam logic [31:0] TIMEOUT_RST      = 32'd100;
  localparam logic [7:0]  CHAN_LO          = 8'd16;
  localparam logic [7:0]  CHAN_HI          = 8'd239;
  localparam logic [7:0]  CHAN_STRIDE      = 8'h10;
  localparam int unsigned HEAD_W           = 3;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned QPTR_W           = 1;
  localparam int unsigned QCNT_W           = 2;

  // one unit of work handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  chan;     // command channel, or channel base of a head
    logic [31:0] mask;     // bits to report
    logic [31:0] status;   // new status word
    logic [7:0]  payload;  // command data
  } job_t;

endpackage

@@ hdl/ccr_front.sv @@
// front end: classifies items, keeps per-head state and builds report and command jobs
module ccr_front import ccr_pkg::*; #(
  parameter int unsigned NUM_HEADS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  op_e         op_i,
  input  logic [7:0]  head_number_i,
  input  logic [31:0] status_word_i,
  input  logic [31:0] timestamp_i,
  input  logic [7:0]  channel_i,
  input  logic [7:0]  payload_i,
  input  logic [31:0] timeout_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam int unsigned IDX_W = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;

  logic [31:0] prev_q [NUM_HEADS];
  logic [31:0] pend_q [NUM_HEADS];
  logic [31:0] time_q [NUM_HEADS];

  logic             head_ok;
  logic [IDX_W-1:0] head_idx;
  logic [31:0]      elapsed;
  logic [31:0]      mask;
  logic [7:0]       base;
  logic             chan_ok;
  logic [8:0]       ch_sum;
  logic [HEAD_W-1:0] ch_head;
  logic [4:0]       ch_bit;
  logic             ch_head_ok;
  logic [IDX_W-1:0] ch_idx;

  always_comb begin
    head_ok  = (head_number_i != 8'd0) && (head_number_i <= 8'(NUM_HEADS));
    head_idx = IDX_W'(head_number_i - 8'd1);
    elapsed  = timestamp_i - (head_ok ? time_q[head_idx] : 32'd0);
    if (!head_ok) begin
      mask = 32'd0;
    end else if (elapsed > timeout_i) begin
      mask = '1;
    end else begin
      mask = pend_q[head_idx] | (prev_q[head_idx] ^ status_word_i);
    end
    // base channel 0x10*(2h-1)
    base = {head_number_i[HEAD_W-1:0], 5'd0} - CHAN_STRIDE;

    chan_ok    = (channel_i >= CHAN_LO) && (channel_i <= CHAN_HI);
    ch_sum     = {1'b0, channel_i} + 9'(CHAN_STRIDE);
    ch_head    = ch_sum[7:5];
    ch_bit     = ch_sum[4:0];
    ch_head_ok = (ch_head != '0) && (32'(ch_head) <= NUM_HEADS);
    ch_idx     = IDX_W'(ch_head - HEAD_W'(1));

    job_o.status  = status_word_i;
    job_o.payload = payload_i;
    if (op_i == OP_COMMAND) begin
      job_o.kind = KIND_COMMAND;
      job_o.chan = channel_i;
      job_o.mask = 32'd0;
      push_o     = accept_i && chan_ok;
    end else begin
      job_o.kind = KIND_REPORT;
      job_o.chan = base;
      job_o.mask = mask;
      push_o     = accept_i && head_ok && (mask != 32'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < NUM_HEADS; h++) begin
        prev_q[h] <= 32'd0;
        pend_q[h] <= 32'd0;
        time_q[h] <= 32'd0;
      end
    end else if (accept_i) begin
      if (op_i == OP_STATUS) begin
        if (head_ok) begin
          prev_q[head_idx] <= status_word_i;
          pend_q[head_idx] <= 32'd0;
          time_q[head_idx] <= timestamp_i;
        end
      end else if (chan_ok && ch_head_ok) begin
        pend_q[ch_idx] <= pend_q[ch_idx] | (32'd1 << ch_bit);
      end
    end
  end

endmodule

@@ hdl/ccr_queue.sv @@
// two-entry job queue between front and back
module ccr_queue import ccr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

`include "channel_change_reporter_unit_macros.svh"

  `CCR_ASSERT(a_no_push_full, full_o && !pop_i |-> !push_i)
  `CCR_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH))

endmodule

@@ hdl/ccr_back.sv @@
// back end: expands a job into result beats, lowest marked bit first
module ccr_back import ccr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        q_job_i,
  output logic        pop_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,
  output logic        m_tuser_o,
  output logic        m_tlast_o
);

  logic        busy_q, busy_d;
  job_t        cur_q;
  logic [31:0] mask_q, mask_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_chan_q, out_chan_d;
  logic [7:0]  out_val_q, out_val_d;
  kind_e       out_kind_q, out_kind_d;
  logic        out_last_q, out_last_d;

  logic        emit;
  logic [31:0] low_bit;
  logic [31:0] rest;
  logic [4:0]  bit_idx;

  assign pop_o = q_valid_i && !busy_q;
  assign emit  = busy_q && (!out_valid_q || m_tready_i);

  always_comb begin
    low_bit = mask_q & (~mask_q + 32'd1);
    rest    = mask_q & (mask_q - 32'd1);
    bit_idx = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (low_bit[i]) bit_idx = bit_idx | 5'(i);
    end

    busy_d      = busy_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_chan_d  = out_chan_q;
    out_val_d   = out_val_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;

    if (pop_o) begin
      busy_d = 1'b1;
      mask_d = q_job_i.mask;
    end else if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = cur_q.kind;
      if (cur_q.kind == KIND_COMMAND) begin
        out_chan_d = cur_q.chan;
        out_val_d  = cur_q.payload;
        out_last_d = 1'b1;
        busy_d     = 1'b0;
      end else begin
        out_chan_d = cur_q.chan + 8'(bit_idx);
        out_val_d  = 8'(cur_q.status[bit_idx]);
        out_last_d = (rest == 32'd0);
        busy_d     = (rest != 32'd0);
        mask_d     = rest;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_job_i;
    mask_q     <= mask_d;
    out_chan_q <= out_chan_d;
    out_val_q  <= out_val_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_val_q, out_chan_q};
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

`include "channel_change_reporter_unit_macros.svh"

  `CCR_ASSERT(a_report_has_bits, busy_q && cur_q.kind == KIND_REPORT |-> mask_q != 32'd0)
  `CCR_ASSERT(a_last_ends_job, emit && out_last_d |=> !busy_q)

endmodule

@@ hdl/channel_change_reporter_unit.sv @@
// channel change reporter: top level with config register and stream ports
// path: an accepted item goes through the job queue, the back end's job
// register and its output register; a command gives one beat, a status report
// one per marked channel; throughput: the back end emits one beat per cycle
// unless the receiver stalls it, and takes a new job only once done with the
// last; the front takes an item per cycle while the two-entry queue has room
// reset: asynchronous, active low; clears all head state, timeout to 100
module channel_change_reporter_unit import ccr_pkg::*; #(
  parameter int unsigned NUM_HEADS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [7:0] head_number, [39:8] status_word, [71:40] timestamp,
  // [79:72] channel, [87:80] payload
  input  logic [87:0] s_tdata_i,
  // [0] operation
  input  logic        s_tuser_i,
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [7:0] report_channel, [15:8] value
  output logic [15:0] m_tdata_o,
  // [0] kind
  output logic        m_tuser_o,
  output logic        m_tlast_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] timeout_q;
  logic        accept;
  logic        push;
  job_t        push_job;
  logic        q_full;
  logic        q_valid;
  job_t        q_job;
  logic        pop;

  // refresh timeout register, only address bit 2 selects a register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_TIMEOUT_IDX[2]) ? timeout_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ADDR_TIMEOUT_IDX[2]) begin
      timeout_q <= pwdata;
    end
  end

  // the front never stalls on its own: it only waits for queue room
  assign s_tready_o = !q_full;
  assign accept     = s_tvalid_i && s_tready_o;

  ccr_front #(
    .NUM_HEADS(NUM_HEADS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op_e'(s_tuser_i)),
    .head_number_i (s_tdata_i[7:0]),
    .status_word_i (s_tdata_i[39:8]),
    .timestamp_i   (s_tdata_i[71:40]),
    .channel_i     (s_tdata_i[79:72]),
    .payload_i     (s_tdata_i[87:80]),
    .timeout_i     (timeout_q),
    .push_o        (push),
    .job_o         (push_job)
  );

  // decouples classification from the per-channel beat expansion
  ccr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  ccr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (q_job),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

@@ sim/ccr_tb_pkg.sv @@
// scoreboard class with the channel change predictor for the testbench
`timescale 1ns / 100ps

package ccr_tb_pkg;
  import ccr_pkg::*;

  localparam int unsigned HEADS      = 7;
  localparam int unsigned PRINT_CAP  = 50;

  class ccr_scoreboard;
    typedef struct {
      kind_e      kind;
      logic [7:0] chan;
      logic [7:0] value;
      logic       last;
    } beat_t;

    logic [31:0] timeout;
    logic [31:0] stored_status [HEADS];
    logic [31:0] pending_bits  [HEADS];
    logic [31:0] report_time   [HEADS];
    beat_t       expected_beats [$];
    int unsigned errors;

    function new();
      timeout = TIMEOUT_RST;
      errors  = 0;
      foreach (stored_status[h]) begin
        stored_status[h] = '0;
        pending_bits[h]  = '0;
        report_time[h]   = '0;
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // writes to any index other than the timeout are dropped
    function void write_reg(int unsigned idx, logic [31:0] data);
      if (idx == ADDR_TIMEOUT_IDX) timeout = data;
    endfunction

    function void push_beat(kind_e kind, logic [7:0] chan, logic [7:0] value, logic last);
      beat_t b;
      b.kind  = kind;
      b.chan  = chan;
      b.value = value;
      b.last  = last;
      expected_beats.push_back(b);
    endfunction

    // works out the beats caused by one accepted item
    function void note_item(op_e op, logic [7:0] head, logic [31:0] status,
                            logic [31:0] stamp, logic [7:0] chan, logic [7:0] payload);
      int unsigned idx;
      int unsigned hd;
      int unsigned nbits;
      logic [31:0] marked;
      logic [31:0] elapsed;
      logic [7:0]  base;
      logic [7:0]  bitpos;
      if (op == OP_STATUS) begin
        if (head < 1 || head > HEADS) return;
        idx     = head - 1;
        elapsed = stamp - report_time[idx];
        if (elapsed > timeout) marked = '1;
        else marked = pending_bits[idx] | (stored_status[idx] ^ status);
        base  = 8'(CHAN_STRIDE * (2 * head - 1));
        nbits = $countones(marked);
        for (int i = 0; i < 32; i++) begin
          if (marked[i]) begin
            nbits--;
            push_beat(KIND_REPORT, base + 8'(i), {7'd0, status[i]}, nbits == 0);
          end
        end
        pending_bits[idx]  = '0;
        stored_status[idx] = status;
        report_time[idx]   = stamp;
      end else begin
        if (chan < CHAN_LO || chan > CHAN_HI) return;
        // a head owns two strides of channels, starting one stride in
        hd     = (int'(chan) + CHAN_STRIDE) / (2 * CHAN_STRIDE);
        bitpos = 8'(int'(chan) - (2 * hd - 1) * CHAN_STRIDE);
        if (hd >= 1 && hd <= HEADS && bitpos < 32)
          pending_bits[hd - 1][bitpos[4:0]] = 1'b1;
        push_beat(KIND_COMMAND, chan, payload, 1'b1);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    task check_beat(kind_e kind, logic [7:0] chan, logic [7:0] value, logic last);
      beat_t b;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat kind %0d chan %0d value %0d last %0d",
                         kind, chan, value, last));
        return;
      end
      b = expected_beats.pop_front();
      if (kind !== b.kind || chan !== b.chan || value !== b.value || last !== b.last)
        report($sformatf("got kind %0d chan %0d value %0d last %0d, want %0d %0d %0d %0d",
                         kind, chan, value, last, b.kind, b.chan, b.value, b.last));
    endtask
  endclass

endpackage

@@ sim/tb_top.sv @@
// testbench top of the channel change reporter with stimulus, handshakes and checking
`timescale 1ns / 100ps

module tb_top;
  import ccr_pkg::*;
  import ccr_tb_pkg::*;

  localparam int unsigned NUM_HEADS     = HEADS;
  localparam int unsigned ADDR_STEP     = 4;
  localparam int unsigned SPARE_IDX     = ADDR_TIMEOUT_IDX + 1;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 40;   // margin for the back end to go quiet
  localparam int unsigned HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int unsigned PHASE_ITEMS   = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [87:0] s_tdata_i  = '0;
  logic        s_tuser_i  = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [15:0] m_tdata_o;
  logic        m_tuser_o;
  logic        m_tlast_o;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  ccr_scoreboard sb = new();

  // stimulus-side view of time and of the last status word sent per head
  logic [31:0] now_s = '0;
  logic [31:0] status_sent [1:NUM_HEADS];

  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  int unsigned hold_left   = 0;
  int unsigned cycles      = 0;

  channel_change_reporter_unit #(.NUM_HEADS(NUM_HEADS)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: every beat taken is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i)
      sb.check_beat(kind_e'(m_tuser_o), m_tdata_o[7:0], m_tdata_o[15:8], m_tlast_o);
  end

  // receiver: short random stalls, plus a long hold-off on request
  initial begin
    int unsigned gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        m_tready_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left   = gap_left - 1;
        m_tready_i <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        gap_left   = $urandom_range(1, 5) - 1;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // one APB transfer; a read is compared with the predicted timeout
  // the bus then idles before the next transfer
  task automatic apb_access(input logic wr, input int unsigned idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'(idx * ADDR_STEP);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && idx == ADDR_TIMEOUT_IDX && prdata !== sb.timeout)
      sb.report($sformatf("timeout reads %0h, want %0h", prdata, sb.timeout));
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // offer one beat, with an optional random gap first, and note it once taken
  task automatic send_beat(input op_e op, input logic [7:0] head, input logic [31:0] status,
                           input logic [31:0] stamp, input logic [7:0] chan,
                           input logic [7:0] payload);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {payload, chan, stamp, status, head};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_item(op, head, status, stamp, chan, payload);
  endtask

  // unused fields carry random junk
  task automatic send_status(input logic [7:0] head, input logic [31:0] status,
                             input logic [31:0] stamp);
    if (head >= 1 && head <= NUM_HEADS) status_sent[head] = status;
    now_s = stamp;
    send_beat(OP_STATUS, head, status, stamp, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_command(input logic [7:0] chan, input logic [7:0] payload);
    send_beat(OP_COMMAND, 8'($urandom), $urandom, $urandom, chan, payload);
  endtask

  // mostly small steps forward, sometimes backwards or a jump anywhere
  function automatic logic [31:0] next_time();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r == 1) return now_s - $urandom_range(1, 50);
    return now_s + $urandom_range(0, 60);
  endfunction

  // one random item; counted is low when the block just drops it
  task automatic send_random(output bit counted);
    int unsigned pick;
    logic [7:0]  head;
    logic [31:0] word;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 60) begin
      head = 8'($urandom_range(1, NUM_HEADS));
      word = status_sent[head];
      if ($urandom_range(0, 4) == 0) word = $urandom;
      else repeat ($urandom_range(0, 3)) word[$urandom_range(0, 31)] ^= 1'b1;
      send_status(head, word, next_time());
    end else if (pick < 85) begin
      send_command(8'($urandom_range(CHAN_LO, CHAN_HI)), 8'($urandom));
    end else if (pick < 93) begin
      head    = 8'($urandom_range(0, 255));
      counted = head >= 1 && head <= NUM_HEADS;
      send_status(head, $urandom, next_time());
    end else begin
      head    = 8'($urandom_range(0, 255));
      counted = head >= CHAN_LO && head <= CHAN_HI;
      send_command(head, 8'($urandom));
    end
  endtask

  // let every expected beat arrive, then give the back end time to go quiet
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [31:0] timeout_val, input bit with_hold);
    int unsigned done;
    bit          counted;
    apb_access(1'b1, ADDR_TIMEOUT_IDX, timeout_val);
    apb_access(1'b0, ADDR_TIMEOUT_IDX, '0);
    done = 0;
    while (done < PHASE_ITEMS) begin
      // stall the receiver for long enough that the job queue fills up
      if (with_hold && done == 5) hold_left = HOLD_CYCLES;
      send_random(counted);
      if (counted) done++;
    end
    wait_idle();
  endtask

  initial begin
    for (int h = 1; h <= NUM_HEADS; h++) status_sent[h] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, ADDR_TIMEOUT_IDX, '0);

    // directed part, timeout at its reset value
    send_status(8'd1, 32'hFFFF_FFFF, 32'd0);   // all bits changed, 32 reports
    send_status(8'd7, 32'h0000_0000, 32'd0);   // nothing marked, no beat
    send_status(8'd0, 32'hFFFF_FFFF, 32'd3);   // head out of range
    send_status(8'd8, 32'hA5A5_A5A5, 32'd3);
    send_status(8'd255, 32'h5A5A_5A5A, 32'd3);
    send_command(8'd16, 8'hA5);                // lowest channel, head 1 bit 0
    send_command(8'd239, 8'hFF);               // highest channel, head 7 bit 31
    send_command(8'd15, 8'h00);                // channel out of range
    send_command(8'd240, 8'h11);
    send_command(8'd0, 8'h22);
    send_command(8'd255, 8'h33);
    send_status(8'd7, 32'h0000_0000, 32'd5);   // only the commanded bit is pending
    send_status(8'd1, 32'hFFFF_FFFF, 32'd6);   // pending bit from channel 16
    send_status(8'd2, 32'h0000_0001, 32'd101); // silent too long: refresh
    send_status(8'd3, 32'h8000_0001, 32'd100); // exactly at the timeout: changes only
    send_command(8'h30, 8'h00);                // head 2 bit 0
    send_status(8'd2, 32'h0000_0001, 32'd150); // pending bit alone
    send_status(8'd1, 32'h0000_00F0, 32'hFFFF_FFF0); // time went backwards: refresh
    send_status(8'd1, 32'h0000_00F1, 32'h0000_0010); // wraps forward, small gap
    send_beat(OP_COMMAND, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd100, 8'h80);
    send_beat(OP_STATUS, 8'd4, 32'h1234_5678, 32'd200, 8'hFF, 8'hFF);
    send_status(8'd5, 32'h0F0F_0F0F, 32'd0);
    wait_idle();

    // a write to the unused index must leave the timeout alone
    apb_access(1'b1, SPARE_IDX, 32'h0000_0007);

    random_phase(32'hFFFF_FFFF, 1'b1);
    random_phase(32'h0000_0000, 1'b0);
    random_phase($urandom_range(0, 200), 1'b0);

    // closing phase without any idling
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    random_phase(TIMEOUT_RST, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
